// ===== rtl/kf800s_pkg.sv =====
// ----------------------------------------------------------------------------
// kf800s_pkg
// Types, constants and helpers shared by the Keccak-f[800] sponge hash.
// ----------------------------------------------------------------------------
package kf800s_pkg;

  localparam int unsigned NUM_LANES = 25;
  localparam int unsigned LANE_W    = 32;
  localparam int unsigned MAX_RNDS  = 22;

  typedef logic [LANE_W-1:0]                lane_t;
  typedef logic [NUM_LANES-1:0][LANE_W-1:0] state_t;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       has_byte;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        last_word;
  } out_word_t;

  // Padding bytes
  localparam logic [7:0] PAD_FIRST = 8'h60;
  localparam logic [7:0] PAD_LAST  = 8'h01;
  localparam logic [7:0] PAD_BOTH  = 8'h61;

  localparam logic [3:0] WORDS_MIN   = 4'd1;
  localparam logic [3:0] WORDS_MAX   = 4'd12;
  localparam logic [3:0] WORDS_RESET = 4'd8;

  localparam lane_t RC [MAX_RNDS] = '{
    32'h00000001, 32'h00008082, 32'h0000808a, 32'h80008000, 32'h0000808b,
    32'h80000001, 32'h80008081, 32'h00008009, 32'h0000008a, 32'h00000088,
    32'h80008009, 32'h8000000a, 32'h8000808b, 32'h0000008b, 32'h00008089,
    32'h00008003, 32'h00008002, 32'h00000080, 32'h0000800a, 32'h8000000a,
    32'h80008081, 32'h00008080
  };

  // rho offsets mod 32, [x][y]
  localparam int RHO [5][5] = '{
    '{0, 4, 3, 9, 18},
    '{1, 12, 10, 13, 2},
    '{30, 6, 11, 15, 29},
    '{28, 23, 25, 21, 24},
    '{27, 20, 7, 8, 14}
  };

  function automatic lane_t rotl(lane_t v, int n);
    logic [2*LANE_W-1:0] t;
    t = {v, v} << n;
    return t[2*LANE_W-1:LANE_W];
  endfunction

  // Byte placed in a lane, most significant byte at offset 0
  function automatic lane_t byte_lane(logic [1:0] sel, logic [7:0] b);
    return LANE_W'(b) << {~sel, 3'b000};
  endfunction

endpackage

// ===== rtl/kf800s_round.sv =====
// ----------------------------------------------------------------------------
// kf800s_round
// One Keccak-f[800] round: theta, rho, pi, chi, iota.
// ----------------------------------------------------------------------------
module kf800s_round (
  input  kf800s_pkg::state_t s_in,
  input  logic [4:0]         rnd,
  output kf800s_pkg::state_t s_out
);

  kf800s_pkg::lane_t c [5];
  kf800s_pkg::lane_t d [5];
  kf800s_pkg::lane_t a [25];
  kf800s_pkg::lane_t b [25];

  always_comb begin
    for (int x = 0; x < 5; x++) begin
      c[x] = s_in[x] ^ s_in[x+5] ^ s_in[x+10] ^ s_in[x+15] ^ s_in[x+20];
    end
    for (int x = 0; x < 5; x++) begin
      d[x] = c[(x+4)%5] ^ kf800s_pkg::rotl(c[(x+1)%5], 1);
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        a[x+5*y] = s_in[x+5*y] ^ d[x];
      end
    end
    // rho and pi
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        b[y+5*((2*x+3*y)%5)] = kf800s_pkg::rotl(a[x+5*y], kf800s_pkg::RHO[x][y]);
      end
    end
    for (int y = 0; y < 5; y++) begin
      for (int x = 0; x < 5; x++) begin
        s_out[x+5*y] = b[x+5*y] ^ (~b[(x+1)%5+5*y] & b[(x+2)%5+5*y]);
      end
    end
    s_out[0] = s_out[0] ^ kf800s_pkg::RC[rnd];
  end

endmodule

// ===== rtl/keccak_f800_sponge_hash.sv =====
// ----------------------------------------------------------------------------
// keccak_f800_sponge_hash
// Sponge hash over Keccak-f[800] with a shared, iterated round unit.
// ----------------------------------------------------------------------------
// Usage:
//   msg channel (msg_valid/msg_stall/msg_word) takes one message byte per word,
//   with has_byte and last flags. msg_stall is high while the block is busy.
//   dgst channel (dgst_valid/dgst_stall/dgst_word) returns digest words, lane
//   order x fastest; last_word marks the final word of a message.
//   cfg channel (cfg_valid/cfg_ready/cfg_data) sets digest_words (1..12, 0 acts
//   as 1, 13..15 as 12); write it only while idle.
// Operation:
//   A byte that does not fill the rate is absorbed while idle. A byte that
//   fills it starts the permutation, one round per cycle through the single
//   round unit, and msg_stall stays high until the permutation ends. A last
//   word adds a pad step, the permutation and the squeeze of the digest
//   words, with a further permutation per further rate's worth of words.
// Reset: lanes and block position clear, digest_words returns to 8.
// Stall: a digest word waits in the output register while dgst_stall is high;
//   the squeeze pauses until it is taken, and the next message can be
//   accepted while the last digest word is still held.
// ----------------------------------------------------------------------------
module keccak_f800_sponge_hash #(
  parameter int ROUNDS = 22
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  msg_valid,
  output logic                  msg_stall,
  input  kf800s_pkg::in_word_t  msg_word,
  output logic                  dgst_valid,
  input  logic                  dgst_stall,
  output kf800s_pkg::out_word_t dgst_word,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [3:0]            cfg_data
);

  localparam int RND_W = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_PERM,
    S_SQZ
  } fsm_t;

  fsm_t               state;
  fsm_t               after;      // where the permutation returns
  logic [RND_W-1:0]   rnd;
  logic [3:0]         dw;         // digest_words register
  logic [6:0]         block_pos;
  logic [3:0]         word_cnt;   // squeezed words so far
  logic [4:0]         lane_idx;   // lane inside current rate block
  kf800s_pkg::state_t lanes;
  kf800s_pkg::state_t lanes_perm;

  logic [3:0]         words;
  logic [6:0]         rate;
  logic [6:0]         rate_m1;
  logic [4:0]         rate_words;
  logic               blk_full;
  logic [6:0]         pad_pos;
  logic               pad_one;    // only one pad byte fits
  logic [7:0]         pad_byte;
  logic               msg_acc;
  logic               dgst_load;
  logic               sqz_done;
  kf800s_pkg::lane_t  absorb_x [25];
  kf800s_pkg::lane_t  pad_x [25];

  // Effective digest length and derived rate
  always_comb begin
    priority if (dw < kf800s_pkg::WORDS_MIN) begin
      words = kf800s_pkg::WORDS_MIN;
    end else if (dw > kf800s_pkg::WORDS_MAX) begin
      words = kf800s_pkg::WORDS_MAX;
    end else begin
      words = dw;
    end
  end

  assign rate       = 7'd100 - 7'({words, 3'b000});
  assign rate_m1    = rate - 7'd1;
  assign rate_words = 5'd25 - 5'({words, 1'b0});
  assign blk_full   = (({1'b0, block_pos} + 8'd1) >= {1'b0, rate});
  assign pad_pos    = (block_pos < rate) ? block_pos : rate_m1;
  assign pad_one    = (pad_pos == rate_m1);
  assign pad_byte   = pad_one ? kf800s_pkg::PAD_BOTH : kf800s_pkg::PAD_FIRST;

  // Lane masks for absorbing one byte and for padding
  always_comb begin
    for (int i = 0; i < 25; i++) begin
      absorb_x[i] = (block_pos[6:2] == 5'(i))
                  ? kf800s_pkg::byte_lane(block_pos[1:0], msg_word.msg_byte) : '0;
      pad_x[i]    = ((pad_pos[6:2] == 5'(i))
                  ? kf800s_pkg::byte_lane(pad_pos[1:0], pad_byte) : '0)
                  ^ ((!pad_one && rate_m1[6:2] == 5'(i))
                  ? kf800s_pkg::byte_lane(rate_m1[1:0], kf800s_pkg::PAD_LAST) : '0);
    end
  end

  kf800s_round u_round (
    .s_in  (lanes),
    .rnd   (5'(rnd)),
    .s_out (lanes_perm)
  );

  assign msg_stall = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign msg_acc   = msg_valid && !msg_stall;
  assign dgst_load = (state == S_SQZ) && (!dgst_valid || !dgst_stall);
  assign sqz_done  = (word_cnt + 4'd1 == words);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      after      <= S_IDLE;
      rnd        <= '0;
      dw         <= kf800s_pkg::WORDS_RESET;
      block_pos  <= '0;
      word_cnt   <= '0;
      lane_idx   <= '0;
      lanes      <= '0;
      dgst_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dw <= cfg_data;
      end
      // taken and not replaced by a new word
      if (dgst_valid && !dgst_stall && !dgst_load) begin
        dgst_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (msg_acc) begin
            if (msg_word.has_byte) begin
              for (int i = 0; i < 25; i++) begin
                lanes[i] <= lanes[i] ^ absorb_x[i];
              end
              if (blk_full) begin
                block_pos <= '0;
                rnd       <= '0;
                state     <= S_PERM;
                after     <= msg_word.last ? S_PAD : S_IDLE;
              end else begin
                block_pos <= block_pos + 7'd1;
                if (msg_word.last) begin
                  state <= S_PAD;
                end
              end
            end else if (msg_word.last) begin
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          for (int i = 0; i < 25; i++) begin
            lanes[i] <= lanes[i] ^ pad_x[i];
          end
          word_cnt <= '0;
          lane_idx <= '0;
          rnd      <= '0;
          state    <= S_PERM;
          after    <= S_SQZ;
        end
        S_PERM: begin
          lanes <= lanes_perm;
          if (rnd == RND_W'(ROUNDS - 1)) begin
            rnd   <= '0;
            state <= after;
          end else begin
            rnd <= rnd + RND_W'(1);
          end
        end
        S_SQZ: begin
          if (dgst_load) begin
            dgst_valid            <= 1'b1;
            dgst_word.digest_word <= lanes[lane_idx];
            dgst_word.last_word   <= sqz_done;
            word_cnt              <= word_cnt + 4'd1;
            if (sqz_done) begin
              lanes     <= '0;
              block_pos <= '0;
              state     <= S_IDLE;
            end else if (lane_idx + 5'd1 == rate_words) begin
              lane_idx <= '0;
              rnd      <= '0;
              state    <= S_PERM;
              after    <= S_SQZ;
            end else begin
              lane_idx <= lane_idx + 5'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_marker_pads: assert property (@(posedge clk) disable iff (rst)
    (msg_acc && msg_word.last && !msg_word.has_byte) |=> state == S_PAD)
    else $error("empty final marker did not start padding");

  a_rnd_idle: assert property (@(posedge clk) disable iff (rst)
    (state != S_PERM) |-> rnd == '0)
    else $error("round counter not cleared outside permutation");

  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQZ) |-> lane_idx < rate_words)
    else $error("squeeze lane beyond rate");

  a_sqz_end: assert property (@(posedge clk) disable iff (rst)
    (dgst_load && sqz_done) |=> state == S_IDLE && block_pos == '0 && lanes == '0)
    else $error("state not cleared after final digest word");

  a_load_valid: assert property (@(posedge clk) disable iff (rst)
    dgst_load |=> dgst_valid)
    else $error("loaded digest word not presented");

endmodule
